// ===== sv/bocv_pkg.sv =====
// Package for the box overlap and center validator: field widths, register
// indexes, reset values, the status code and the item structs.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package bocv_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int COORD_W = 16;
    localparam int DIM_W   = 15;
    localparam int OVL_W   = 17;
    localparam int DIST_W  = 21;
    localparam int AREA_W  = 30;
    localparam int OTHR_W  = 17;
    localparam int CTHR_W  = 16;
    localparam int UN_W    = 31;
    localparam int DIAG_W  = 31;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_OVL_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CTR_THR = 2'd1;

    localparam logic [OTHR_W-1:0] OVL_THR_RST = 17'd32768;
    localparam logic [CTHR_W-1:0] CTR_THR_RST = 16'd128;

    typedef enum logic [1:0] {
        ST_VALID   = 2'd0,
        ST_LOST    = 2'd1,
        ST_LOW_OVL = 2'd2,
        ST_CENTER  = 2'd3
    } t_status;

    typedef struct packed {
        logic signed [COORD_W-1:0] ref_x;
        logic signed [COORD_W-1:0] ref_y;
        logic [DIM_W-1:0]          ref_w;
        logic [DIM_W-1:0]          ref_h;
        logic signed [COORD_W-1:0] trk_x;
        logic signed [COORD_W-1:0] trk_y;
        logic [DIM_W-1:0]          trk_w;
        logic [DIM_W-1:0]          trk_h;
        logic                      lost;
    } t_item_in;

    typedef struct packed {
        t_status             status;
        logic [OVL_W-1:0]    overlap;
        logic [DIST_W-1:0]   center_distance;
        logic [AREA_W-1:0]   tracked_area;
    } t_item_out;

endpackage

`default_nettype wire

// ===== sv/box_overlap_center_validator.sv =====
// Top level of the box overlap and center validator: a fully pipelined
// datapath with a bit-per-stage divider and square root. Depends on bocv_pkg.
//
//   Channel   Ports                                   Direction  Handshake
//   input     i_start, o_busy, i_item                 in         start & !busy
//   result    o_valid, o_result                       out        strobe, one cycle
//   config    i_cfg_valid, o_cfg_ready, i_cfg_index,  in         valid & ready
//             i_cfg_data
//
// One item is accepted in every clock cycle; o_busy never rises. Four
// front stages form the areas, the center offsets and the threshold
// products; then NSTEP stages each resolve a quotient bit of the overlap,
// a root bit of the center distance or both, so the wider of the root
// (about COORD_BITS + 7 bits) and the quotient (FRAC_BITS + 1 bits) sets
// the depth; an output register follows. Reset clears the valid bits and
// loads the threshold registers with their reset values. The receiver
// cannot stall, so results are simply presented for one cycle each.
`default_nettype none

module box_overlap_center_validator
    import bocv_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    output logic                       o_busy,
    input  wire t_item_in              i_item,
    output logic                       o_valid,
    output t_item_out                  o_result,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Coordinate, edge and center-offset widths follow from COORD_BITS.
    localparam int XW    = COORD_BITS + 1;
    localparam int SW    = ((XW > 16) ? XW : 16) + 1;
    localparam int DW    = SW + 2;
    localparam int SSW   = 2 * DW - 1;
    localparam int SQW0  = SSW + 6;
    localparam int SQW   = SQW0 + (SQW0 % 2);
    localparam int RB    = SQW / 2;
    localparam int RW    = RB + 3;
    localparam int QB    = FRAC_BITS + 1;
    localparam int NSTEP = (RB > QB) ? RB : QB;
    localparam int CP_W  = 2 * CTHR_W + DIAG_W;
    localparam int CMPW  = ((SSW + 14) > CP_W) ? (SSW + 14) : CP_W;
    localparam int OP_W  = OTHR_W + UN_W;
    localparam int LATENCY = NSTEP + 5;

    // ------------------------------------------------------------------
    // Configuration registers. The squared center threshold is kept in a
    // register of its own so the later product starts from a flop.
    // ------------------------------------------------------------------
    logic [OTHR_W-1:0]   r_ovl_thr;
    logic [CTHR_W-1:0]   r_ctr_thr;
    logic [2*CTHR_W-1:0] r_ct_sq;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovl_thr <= OVL_THR_RST;
            r_ctr_thr <= CTR_THR_RST;
            r_ct_sq   <= (2*CTHR_W)'(CTR_THR_RST) * (2*CTHR_W)'(CTR_THR_RST);
        end else begin
            r_ct_sq <= (2*CTHR_W)'(r_ctr_thr) * (2*CTHR_W)'(r_ctr_thr);
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_OVL_THR: r_ovl_thr <= i_cfg_data[OTHR_W-1:0];
                    REG_CTR_THR: r_ctr_thr <= i_cfg_data[CTHR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Coordinate decode: two's complement in COORD_BITS bits. A field
    // narrower than COORD_BITS has no sign bit there and reads as positive.
    // ------------------------------------------------------------------
    logic signed [XW-1:0] c_rx, c_ry, c_tx, c_ty;

    generate
        if (COORD_BITS > COORD_W) begin : g_zext
            assign c_rx = XW'($signed({1'b0, i_item.ref_x}));
            assign c_ry = XW'($signed({1'b0, i_item.ref_y}));
            assign c_tx = XW'($signed({1'b0, i_item.trk_x}));
            assign c_ty = XW'($signed({1'b0, i_item.trk_y}));
        end else begin : g_sext
            assign c_rx = XW'($signed(i_item.ref_x[COORD_BITS-1:0]));
            assign c_ry = XW'($signed(i_item.ref_y[COORD_BITS-1:0]));
            assign c_tx = XW'($signed(i_item.trk_x[COORD_BITS-1:0]));
            assign c_ty = XW'($signed(i_item.trk_y[COORD_BITS-1:0]));
        end
    endgenerate

    // ------------------------------------------------------------------
    // Stage F0: intersection extents and doubled center offsets.
    // ------------------------------------------------------------------
    logic                 r_f0_vld;
    logic [DIM_W-1:0]     r_f0_iw, r_f0_ih, n_f0_iw, n_f0_ih;
    logic                 r_f0_iok, r_f0_hok, n_f0_iok, n_f0_hok;
    logic signed [DW-1:0] r_f0_dx, r_f0_dy, n_f0_dx, n_f0_dy;
    logic [DIM_W-1:0]     r_f0_rw, r_f0_rh, r_f0_tw, r_f0_th;
    logic                 r_f0_lost;

    always_comb begin
        logic signed [SW-1:0] x0, y0, x1, y1, w0, h0, w1, h1;
        logic signed [SW-1:0] lo_x, lo_y, hi_x, hi_y;
        logic signed [SW:0]   iw, ih;
        x0 = SW'(c_rx);
        y0 = SW'(c_ry);
        x1 = SW'(c_tx);
        y1 = SW'(c_ty);
        w0 = $signed(SW'(i_item.ref_w));
        h0 = $signed(SW'(i_item.ref_h));
        w1 = $signed(SW'(i_item.trk_w));
        h1 = $signed(SW'(i_item.trk_h));
        lo_x = (x0 > x1) ? x0 : x1;
        lo_y = (y0 > y1) ? y0 : y1;
        hi_x = ((x0 + w0) < (x1 + w1)) ? (x0 + w0) : (x1 + w1);
        hi_y = ((y0 + h0) < (y1 + h1)) ? (y0 + h0) : (y1 + h1);
        iw = (SW+1)'(hi_x) - (SW+1)'(lo_x);
        ih = (SW+1)'(hi_y) - (SW+1)'(lo_y);
        // A positive extent never exceeds the smaller box dimension.
        n_f0_iok = iw > 0;
        n_f0_hok = ih > 0;
        n_f0_iw  = iw[DIM_W-1:0];
        n_f0_ih  = ih[DIM_W-1:0];
        n_f0_dx  = (DW'(x0) <<< 1) + DW'(w0) - (DW'(x1) <<< 1) - DW'(w1);
        n_f0_dy  = (DW'(y0) <<< 1) + DW'(h0) - (DW'(y1) <<< 1) - DW'(h1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f0_vld <= 1'b0;
        end else begin
            r_f0_vld <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f0_iw   <= n_f0_iw;
        r_f0_ih   <= n_f0_ih;
        r_f0_iok  <= n_f0_iok;
        r_f0_hok  <= n_f0_hok;
        r_f0_dx   <= n_f0_dx;
        r_f0_dy   <= n_f0_dy;
        r_f0_rw   <= i_item.ref_w;
        r_f0_rh   <= i_item.ref_h;
        r_f0_tw   <= i_item.trk_w;
        r_f0_th   <= i_item.trk_h;
        r_f0_lost <= i_item.lost;
    end

    // ------------------------------------------------------------------
    // Stage F1: areas, squared center distance and squared diagonal.
    // ------------------------------------------------------------------
    logic              r_f1_vld, r_f1_lost;
    logic [AREA_W-1:0] r_f1_ia, r_f1_ra, r_f1_ta;
    logic [SSW-1:0]    r_f1_s, n_f1_s;
    logic [DIAG_W-1:0] r_f1_diag2;

    always_comb begin
        logic signed [2*DW-1:0] mx, my;
        mx = (2*DW)'(r_f0_dx) * (2*DW)'(r_f0_dx);
        my = (2*DW)'(r_f0_dy) * (2*DW)'(r_f0_dy);
        n_f1_s = SSW'($unsigned(mx[2*DW-3:0])) + SSW'($unsigned(my[2*DW-3:0]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
        end else begin
            r_f1_vld <= r_f0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1_lost  <= r_f0_lost;
        r_f1_ia    <= (r_f0_iok && r_f0_hok) ?
                      (AREA_W'(r_f0_iw) * AREA_W'(r_f0_ih)) : '0;
        r_f1_ra    <= AREA_W'(r_f0_rw) * AREA_W'(r_f0_rh);
        r_f1_ta    <= AREA_W'(r_f0_tw) * AREA_W'(r_f0_th);
        r_f1_s     <= n_f1_s;
        r_f1_diag2 <= DIAG_W'(r_f0_rw) * DIAG_W'(r_f0_rw)
                    + DIAG_W'(r_f0_rh) * DIAG_W'(r_f0_rh);
    end

    // ------------------------------------------------------------------
    // Stage F2: union and the center threshold product.
    // ------------------------------------------------------------------
    logic              r_f2_vld, r_f2_lost;
    logic [AREA_W-1:0] r_f2_ia, r_f2_ta;
    logic [UN_W-1:0]   r_f2_un;
    logic [SSW-1:0]    r_f2_s;
    logic [CP_W-1:0]   r_f2_cprod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_vld <= 1'b0;
        end else begin
            r_f2_vld <= r_f1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f2_lost  <= r_f1_lost;
        r_f2_ia    <= r_f1_ia;
        r_f2_ta    <= r_f1_ta;
        r_f2_un    <= UN_W'(r_f1_ra) + UN_W'(r_f1_ta) - UN_W'(r_f1_ia);
        r_f2_s     <= r_f1_s;
        r_f2_cprod <= CP_W'(r_ct_sq) * CP_W'(r_f1_diag2);
    end

    // ------------------------------------------------------------------
    // Stage F3: overlap threshold product and the center test.
    // ------------------------------------------------------------------
    logic              r_f3_vld, r_f3_lost, r_f3_cfail;
    logic [AREA_W-1:0] r_f3_ia, r_f3_ta;
    logic [UN_W-1:0]   r_f3_un;
    logic [SSW-1:0]    r_f3_s;
    logic [OP_W-1:0]   r_f3_oprod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f3_vld <= 1'b0;
        end else begin
            r_f3_vld <= r_f2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f3_lost  <= r_f2_lost;
        r_f3_ia    <= r_f2_ia;
        r_f3_ta    <= r_f2_ta;
        r_f3_un    <= r_f2_un;
        r_f3_s     <= r_f2_s;
        r_f3_oprod <= OP_W'(r_ovl_thr) * OP_W'(r_f2_un);
        r_f3_cfail <= (CMPW'(r_f2_s) << 14) > CMPW'(r_f2_cprod);
    end

    // ------------------------------------------------------------------
    // Digit stages. Index 0 of each p_ array is the seed from F3; index k + 1
    // is the register after step k. Step k yields quotient bit k of the overlap
    // (integer bit first) if k < QB and root bit k of the distance if k < RB.
    // ------------------------------------------------------------------
    logic [31:0]       p_drem  [NSTEP+1];
    logic [QB-1:0]     p_q     [NSTEP+1];
    logic [UN_W-1:0]   p_un    [NSTEP+1];
    logic [SQW-1:0]    p_n     [NSTEP+1];
    logic [RB-1:0]     p_root  [NSTEP+1];
    logic [RW-1:0]     p_srem  [NSTEP+1];
    logic [AREA_W-1:0] p_ta    [NSTEP+1];
    logic              p_ofail [NSTEP+1];
    logic              p_cfail [NSTEP+1];
    logic              p_lost  [NSTEP+1];
    logic              p_vld   [NSTEP+1];

    logic [31:0]       r_drem  [NSTEP];
    logic [QB-1:0]     r_q     [NSTEP];
    logic [UN_W-1:0]   r_un    [NSTEP];
    logic [SQW-1:0]    r_n     [NSTEP];
    logic [RB-1:0]     r_root  [NSTEP];
    logic [RW-1:0]     r_srem  [NSTEP];
    logic [AREA_W-1:0] r_ta    [NSTEP];
    logic              r_ofail [NSTEP];
    logic              r_cfail [NSTEP];
    logic              r_lost  [NSTEP];
    logic              r_vld   [NSTEP];

    logic [31:0]       n_drem  [NSTEP];
    logic [QB-1:0]     n_q     [NSTEP];
    logic [SQW-1:0]    n_n     [NSTEP];
    logic [RB-1:0]     n_root  [NSTEP];
    logic [RW-1:0]     n_srem  [NSTEP];

    assign p_drem[0]  = 32'(r_f3_ia);
    assign p_q[0]     = '0;
    assign p_un[0]    = r_f3_un;
    assign p_n[0]     = SQW'(r_f3_s) << 6;
    assign p_root[0]  = '0;
    assign p_srem[0]  = '0;
    assign p_ta[0]    = r_f3_ta;
    assign p_ofail[0] = (OP_W'(r_f3_ia) << 16) < r_f3_oprod;
    assign p_cfail[0] = r_f3_cfail;
    assign p_lost[0]  = r_f3_lost;
    assign p_vld[0]   = r_f3_vld;

    generate
        for (genvar k = 0; k < NSTEP; k++) begin : g_step
            always_comb begin
                logic [31:0]   t;
                logic          dge;
                logic [RW-1:0] cur, trial;
                logic          sge;
                // The remainder stays below the union, so the doubled
                // remainder fits in 32 bits.
                t     = (k == 0) ? p_drem[k] : (p_drem[k] << 1);
                dge   = t >= {1'b0, p_un[k]};
                cur   = (p_srem[k] << 2) | RW'(p_n[k][SQW-1 -: 2]);
                trial = (RW'(p_root[k]) << 2) | RW'(1);
                sge   = cur >= trial;
                n_drem[k] = p_drem[k];
                n_q[k]    = p_q[k];
                n_n[k]    = p_n[k];
                n_root[k] = p_root[k];
                n_srem[k] = p_srem[k];
                if (k < QB) begin
                    n_drem[k] = dge ? (t - {1'b0, p_un[k]}) : t;
                    n_q[k]    = {p_q[k][QB-2:0], dge};
                end
                if (k < RB) begin
                    n_n[k]    = p_n[k] << 2;
                    n_root[k] = {p_root[k][RB-2:0], sge};
                    n_srem[k] = sge ? (cur - trial) : cur;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else begin
                    r_vld[k] <= p_vld[k];
                end
            end

            always_ff @(posedge i_clk) begin
                r_drem[k]  <= n_drem[k];
                r_q[k]     <= n_q[k];
                r_un[k]    <= p_un[k];
                r_n[k]     <= n_n[k];
                r_root[k]  <= n_root[k];
                r_srem[k]  <= n_srem[k];
                r_ta[k]    <= p_ta[k];
                r_ofail[k] <= p_ofail[k];
                r_cfail[k] <= p_cfail[k];
                r_lost[k]  <= p_lost[k];
            end

            assign p_drem[k+1]  = r_drem[k];
            assign p_q[k+1]     = r_q[k];
            assign p_un[k+1]    = r_un[k];
            assign p_n[k+1]     = r_n[k];
            assign p_root[k+1]  = r_root[k];
            assign p_srem[k+1]  = r_srem[k];
            assign p_ta[k+1]    = r_ta[k];
            assign p_ofail[k+1] = r_ofail[k];
            assign p_cfail[k+1] = r_cfail[k];
            assign p_lost[k+1]  = r_lost[k];
            assign p_vld[k+1]   = r_vld[k];
        end
    endgenerate

    // ------------------------------------------------------------------
    // Output stage. The root remainder is n - root^2, so rounding half up
    // adds one exactly when that remainder exceeds the root. A zero union
    // leaves the divider saturated, and the overlap is forced to zero.
    // The center test wins over the overlap test; a lost item wins over
    // both and zeroes every value.
    // ------------------------------------------------------------------
    logic      r_out_vld;
    t_item_out r_out, n_out;

    always_comb begin
        logic [RB:0] d;
        d = (RB+1)'(p_root[NSTEP])
          + (RB+1)'(p_srem[NSTEP] > RW'(p_root[NSTEP]));
        n_out.status          = p_cfail[NSTEP] ? ST_CENTER :
                                p_ofail[NSTEP] ? ST_LOW_OVL : ST_VALID;
        n_out.overlap         = (p_un[NSTEP] == '0) ? '0 : OVL_W'(p_q[NSTEP]);
        n_out.center_distance = DIST_W'(d);
        n_out.tracked_area    = p_ta[NSTEP];
        if (p_lost[NSTEP]) begin
            n_out.status          = ST_LOST;
            n_out.overlap         = '0;
            n_out.center_distance = '0;
            n_out.tracked_area    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= p_vld[NSTEP];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

`ifndef SYNTHESIS
    // Every accepted item comes out after the fixed pipeline latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LATENCY o_valid)
        else $error("accepted item did not leave after the pipeline latency");

    // No result appears without an item accepted the latency earlier.
    a_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, LATENCY))
        else $error("result strobe without a matching accepted item");

    // A lost item carries only zero values.
    a_lost_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == ST_LOST) |->
        (o_result.overlap == '0 && o_result.center_distance == '0 &&
         o_result.tracked_area == '0))
        else $error("lost item with nonzero values");

    // The block never holds off an item or a register write.
    a_always_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_busy && o_cfg_ready))
        else $error("input or configuration channel not ready");
`endif

endmodule

`default_nettype wire
